// ===== rtl/core/lbg_pkg.sv =====
// Package for the LBP bit-plane gradient unit.
// Holds sizes, register codes, payload types and the neighbor table.
// No dependencies; compiled first.
package lbg_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int SAMPLE_BITS = 16;
    localparam int COL_BITS    = $clog2(MAX_WIDTH);
    localparam int WIDTH_BITS  = 11;
    localparam int HEIGHT_BITS = 12;
    localparam int BORDER_BITS = 8;
    localparam int CODE_BITS   = 8;
    localparam int FIDX_BITS   = 20;
    localparam int ADDR_BITS   = 4;
    localparam int DATA_BITS   = 32;
    localparam int CMP_BITS    = (COL_BITS + 2 > HEIGHT_BITS + 2) ? COL_BITS + 2
                                                                  : HEIGHT_BITS + 2;

    localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [1:0] REG_BORDER       = 2'd2;

    localparam logic [WIDTH_BITS-1:0]  WIDTH_RESET  = 11'd640;
    localparam logic [HEIGHT_BITS-1:0] HEIGHT_RESET = 12'd480;
    localparam logic [BORDER_BITS-1:0] BORDER_RESET = 8'd10;
    localparam logic [BORDER_BITS-1:0] MIN_BORDER   = 8'd2;

    localparam int WIN_CENTER = 4;

    // window position of neighbor k, clockwise from top-left
    localparam logic [3:0] NBR_POS [CODE_BITS] = '{
        4'd0, 4'd1, 4'd2, 4'd5, 4'd8, 4'd7, 4'd6, 4'd3
    };

    typedef logic [SAMPLE_BITS-1:0] t_sample;
    typedef logic [CODE_BITS-1:0]   t_code;
    typedef logic [8:0][SAMPLE_BITS-1:0] t_window;

    typedef struct packed {
        logic code;
        logic out;
        logic ring;
        logic first;
        logic last;
    } t_flags;

    typedef struct packed {
        t_code                  lbp_code;
        t_code                  dx_plus;
        t_code                  dx_minus;
        t_code                  dy_plus;
        t_code                  dy_minus;
        logic [FIDX_BITS-1:0]   feature_index;
        logic                   frame_end;
    } t_result;

endpackage

// ===== rtl/core/lbg_in_if.sv =====
// Sample stream channel: valid/ready with the blurred sample payload.
// Depends on lbg_pkg.
interface lbg_in_if import lbg_pkg::*; ();
    logic    valid;
    logic    ready;
    t_sample blurred_sample;

    modport source (output valid, output blurred_sample, input ready);
    modport sink   (input valid, input blurred_sample, output ready);
endinterface

// ===== rtl/core/lbg_out_if.sv =====
// Result channel: valid/ready with pattern, gradient masks and index.
// Depends on lbg_pkg.
interface lbg_out_if import lbg_pkg::*; ();
    logic                 valid;
    logic                 ready;
    t_code                lbp_code;
    t_code                dx_plus;
    t_code                dx_minus;
    t_code                dy_plus;
    t_code                dy_minus;
    logic [FIDX_BITS-1:0] feature_index;
    logic                 frame_end;

    modport source (output valid, output lbp_code, output dx_plus, output dx_minus,
                    output dy_plus, output dy_minus, output feature_index,
                    output frame_end, input ready);
    modport sink   (input valid, input lbp_code, input dx_plus, input dx_minus,
                    input dy_plus, input dy_minus, input feature_index,
                    input frame_end, output ready);
endinterface

// ===== rtl/core/lbp_bitplane_gradient_unit.sv =====
// Top level of the LBP bit-plane gradient unit.
// Depends on lbg_pkg, lbg_in_if, lbg_out_if, lbg_ram and lbg_pattern.
//
// Takes blurred samples in raster order and returns, for each pixel of the
// feature region, its 3x3 local binary pattern with the left/right and up/down
// plus/minus masks (zero on the outer feature ring), its raster index in the
// region and an end-of-frame flag. Throughput is one sample per cycle when not
// stalled; a result passes the stage 1, window and output registers after the
// sample that completes its neighborhood, i.e. the sample two rows down and one
// column right. Two line RAMs of MAX_WIDTH words (two sample rows and two code
// rows packed per word) supply the neighborhood; their contents need no
// clearing after reset. Writing any of frame_width, frame_height or border
// restarts the frame at row 0, column 0; write only while the block is idle.
module lbp_bitplane_gradient_unit import lbg_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    lbg_in_if.sink               i_pix,
    lbg_out_if.source            o_res,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_BITS-1:0] paddr,
    input  logic [DATA_BITS-1:0] pwdata,
    output logic [DATA_BITS-1:0] prdata,
    output logic                 pready
);

    // configuration
    logic [WIDTH_BITS-1:0]  r_frame_width;
    logic [HEIGHT_BITS-1:0] r_frame_height;
    logic [BORDER_BITS-1:0] r_border;
    logic                   cfg_wr;
    logic                   cfg_hit;
    logic [1:0]             cfg_idx;

    // frame position
    logic [COL_BITS-1:0]    r_col;
    logic [HEIGHT_BITS-1:0] r_row;
    logic [COL_BITS-1:0]    n_col;
    logic [HEIGHT_BITS-1:0] n_row;

    // derived limits
    logic [CMP_BITS-1:0] weff, beff, hx, cx, rx;
    logic [CMP_BITS-1:0] row_lo, row_hi, col_lo, col_hi;
    logic                frame_ok;
    t_flags              n_flags;

    // pipeline
    logic                 en, accept;
    logic                 r_s1_valid, r_s2_valid, r_out_valid;
    t_flags               r_s1_flags, r_s2_flags;
    t_sample              r_s1_sample;
    logic [COL_BITS-1:0]  r_s1_col, r_s2_addr;
    t_window              r_win;
    t_code                r_mid [3];
    t_code                r_up_new, r_up_cur;
    logic [2*SAMPLE_BITS-1:0] smp_rdata;
    logic [2*CODE_BITS-1:0]   code_rdata;
    t_code                here;
    t_result              r_res, n_res;
    logic [FIDX_BITS-1:0] r_fidx, fidx;
    logic                 code_we;

    // ---------------- configuration port ----------------
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[3:2];
    assign cfg_hit = cfg_wr && (cfg_idx == REG_FRAME_WIDTH || cfg_idx == REG_FRAME_HEIGHT ||
                                cfg_idx == REG_BORDER);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= WIDTH_RESET;
            r_frame_height <= HEIGHT_RESET;
            r_border       <= BORDER_RESET;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_FRAME_WIDTH:  r_frame_width  <= pwdata[WIDTH_BITS-1:0];
                REG_FRAME_HEIGHT: r_frame_height <= pwdata[HEIGHT_BITS-1:0];
                REG_BORDER:       r_border       <= pwdata[BORDER_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_FRAME_WIDTH:  prdata = DATA_BITS'(r_frame_width);
            REG_FRAME_HEIGHT: prdata = DATA_BITS'(r_frame_height);
            REG_BORDER:       prdata = DATA_BITS'(r_border);
            default:          prdata = '0;
        endcase
    end

    // ---------------- position and region flags ----------------
    assign weff = (CMP_BITS'(r_frame_width) > CMP_BITS'(MAX_WIDTH)) ? CMP_BITS'(MAX_WIDTH)
                                                                    : CMP_BITS'(r_frame_width);
    assign beff = (r_border < MIN_BORDER) ? CMP_BITS'(MIN_BORDER) : CMP_BITS'(r_border);
    assign hx   = CMP_BITS'(r_frame_height);
    assign cx   = CMP_BITS'(r_col);
    assign rx   = CMP_BITS'(r_row);

    assign frame_ok = (weff > (beff << 1)) && (hx > (beff << 1));
    assign row_lo   = beff + CMP_BITS'(2);
    assign row_hi   = hx - beff + CMP_BITS'(1);
    assign col_lo   = beff + CMP_BITS'(1);
    assign col_hi   = weff - beff;

    always_comb begin
        n_flags.code  = frame_ok && rx >= CMP_BITS'(2) && cx >= CMP_BITS'(2);
        n_flags.out   = n_flags.code && rx >= row_lo && rx <= row_hi &&
                        cx >= col_lo && cx <= col_hi;
        n_flags.ring  = rx == row_lo || rx == row_hi || cx == col_lo || cx == col_hi;
        n_flags.first = rx == row_lo && cx == col_lo;
        n_flags.last  = rx == row_hi && cx == col_hi;
    end

    always_comb begin
        n_col = r_col + COL_BITS'(1);
        n_row = r_row;
        if (cx + CMP_BITS'(1) >= weff) begin
            n_col = '0;
            n_row = (rx + CMP_BITS'(1) >= hx) ? '0 : r_row + HEIGHT_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (cfg_hit) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // ---------------- handshake ----------------
    assign en          = !r_out_valid || o_res.ready;
    assign accept      = i_pix.valid && en;
    assign i_pix.ready = en;

    // ---------------- line RAMs ----------------
    // sample word: {row r-2, row r-1} at column c
    lbg_ram #(
        .WIDTH (2*SAMPLE_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_sample_ram (
        .i_clk   (i_clk),
        .i_we    (en && r_s1_valid),
        .i_waddr (r_s1_col),
        .i_wdata ({smp_rdata[SAMPLE_BITS-1:0], r_s1_sample}),
        .i_re    (accept),
        .i_raddr (r_col),
        .o_rdata (smp_rdata)
    );

    // code word: {row R-2, row R-1} at column C
    assign code_we = en && r_s2_valid && r_s2_flags.code;

    lbg_ram #(
        .WIDTH (2*CODE_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_code_ram (
        .i_clk   (i_clk),
        .i_we    (code_we),
        .i_waddr (r_s2_addr),
        .i_wdata ({r_mid[1], here}),
        .i_re    (accept),
        .i_raddr (r_col),
        .o_rdata (code_rdata)
    );

    // ---------------- stage 1 ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (en) begin
            r_s1_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_flags  <= n_flags;
            r_s1_sample <= i_pix.blurred_sample;
            r_s1_col    <= r_col;
        end
    end

    // window and code row shift, one column per transaction
    always_ff @(posedge i_clk) begin
        if (en && r_s1_valid) begin
            for (int i = 0; i < 3; i++) begin
                r_win[i*3]   <= r_win[i*3+1];
                r_win[i*3+1] <= r_win[i*3+2];
            end
            r_win[2]  <= smp_rdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
            r_win[5]  <= smp_rdata[SAMPLE_BITS-1:0];
            r_win[8]  <= r_s1_sample;
            r_mid[0]  <= r_mid[1];
            r_mid[1]  <= r_mid[2];
            r_mid[2]  <= code_rdata[CODE_BITS-1:0];
            r_up_cur  <= r_up_new;
            r_up_new  <= code_rdata[2*CODE_BITS-1:CODE_BITS];
            r_s2_flags <= r_s1_flags;
            r_s2_addr  <= r_s1_col - COL_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (en) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    // ---------------- stage 2 ----------------
    lbg_pattern u_pattern (
        .i_window (r_win),
        .o_code   (here)
    );

    assign fidx = r_s2_flags.first ? '0 : r_fidx;

    always_comb begin
        n_res.lbp_code      = r_mid[1];
        n_res.dx_plus       = r_s2_flags.ring ? '0 : (r_mid[0] & ~r_mid[2]);
        n_res.dx_minus      = r_s2_flags.ring ? '0 : (~r_mid[0] & r_mid[2]);
        n_res.dy_plus       = r_s2_flags.ring ? '0 : (r_up_cur & ~here);
        n_res.dy_minus      = r_s2_flags.ring ? '0 : (~r_up_cur & here);
        n_res.feature_index = fidx;
        n_res.frame_end     = r_s2_flags.last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_fidx      <= '0;
        end else if (en) begin
            r_out_valid <= r_s2_valid && r_s2_flags.out;
            if (r_s2_valid && r_s2_flags.out) begin
                r_fidx <= fidx + FIDX_BITS'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_res <= n_res;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.lbp_code      = r_res.lbp_code;
    assign o_res.dx_plus       = r_res.dx_plus;
    assign o_res.dx_minus      = r_res.dx_minus;
    assign o_res.dy_plus       = r_res.dy_plus;
    assign o_res.dy_minus      = r_res.dy_minus;
    assign o_res.feature_index = r_res.feature_index;
    assign o_res.frame_end     = r_res.frame_end;

    // ---------------- assertions ----------------
    a_end_on_ring: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_res.frame_end |->
            r_res.dx_plus == '0 && r_res.dx_minus == '0 &&
            r_res.dy_plus == '0 && r_res.dy_minus == '0)
        else $error("frame end result carries nonzero masks");

    a_masks_disjoint: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_res.dx_plus & r_res.dx_minus) == '0 &&
                        (r_res.dy_plus & r_res.dy_minus) == '0)
        else $error("plus and minus masks overlap");

    a_out_needs_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_valid && r_s2_flags.out |-> r_s2_flags.code)
        else $error("result without a computed pattern");

    a_cfg_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_hit |=> r_row == '0 && r_col == '0)
        else $error("register write did not restart the frame");

endmodule

// ===== rtl/core/lbg_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module lbg_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/lbg_pattern.sv =====
// 3x3 local binary pattern: bit k set when neighbor k is below the center.
// Depends on lbg_pkg (window type, neighbor table).
module lbg_pattern import lbg_pkg::*; (
    input  t_window i_window,
    output t_code   o_code
);

    always_comb begin
        for (int k = 0; k < CODE_BITS; k++) begin
            o_code[k] = i_window[NBR_POS[k]] < i_window[WIN_CENTER];
        end
    end

endmodule
